>>> design/ehpsd_pkg.sv
// Package for the exception-table pointer decoder: types, codes and format decode.
`timescale 1ns / 1ps
`default_nettype none
package ehpsd_pkg;

  // Encoding byte values and masks
  localparam logic [7:0] ENC_OMIT   = 8'hFF;
  localparam logic [6:0] GROUP_MASK = 7'h7F;

  // Format codes (low nibble of the encoding)
  localparam logic [3:0] FMT_ULEB128 = 4'h1;
  localparam logic [3:0] FMT_UDATA2  = 4'h2;
  localparam logic [3:0] FMT_UDATA4  = 4'h3;
  localparam logic [3:0] FMT_UDATA8  = 4'h4;
  localparam logic [3:0] FMT_SDATA2  = 4'hA;
  localparam logic [3:0] FMT_SDATA4  = 4'hB;
  localparam logic [3:0] FMT_SDATA8  = 4'hC;

  // Application codes (high nibble) that mark a relocatable value
  localparam logic [3:0] APP_ABSPTR  = 4'h0;
  localparam logic [3:0] APP_PCREL   = 4'h1;
  localparam logic [3:0] APP_DATAREL = 4'h3;

  // Field length codes
  localparam logic [3:0] LEN_ULEB    = 4'd0;
  localparam logic [3:0] LEN_UNKNOWN = 4'd15;

  // Highest ULEB group index that still lands below bit 64
  localparam logic [7:0] ULEB_LAST_GROUP = 8'd9;
  localparam logic [7:0] COUNT_MAX       = 8'd255;

  // Input command codes
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OMIT     = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_NO_VALUE = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] encoding;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic        busy;
    logic [7:0]  encoding;
    logic [63:0] acc;
    logic [7:0]  count;
  } dec_state_t;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  bytes_used;
    logic        relocatable;
    status_e     status;
  } result_t;

  // Field length in bytes; LEN_ULEB for ULEB128, LEN_UNKNOWN otherwise unknown
  function automatic logic [3:0] fmt_len(input logic [7:0] enc);
    logic [3:0] len;
    unique case (enc[3:0])
      FMT_ULEB128:             len = LEN_ULEB;
      FMT_UDATA2, FMT_SDATA2:  len = 4'd2;
      FMT_UDATA4, FMT_SDATA4:  len = 4'd4;
      FMT_UDATA8, FMT_SDATA8:  len = 4'd8;
      default:                 len = LEN_UNKNOWN;
    endcase
    return len;
  endfunction

  function automatic logic fmt_signed(input logic [7:0] enc);
    return (enc[3:0] == FMT_SDATA2) || (enc[3:0] == FMT_SDATA4) ||
           (enc[3:0] == FMT_SDATA8);
  endfunction

  function automatic logic is_reloc(input logic [7:0] enc);
    return (enc[7:4] == APP_ABSPTR) || (enc[7:4] == APP_PCREL) ||
           (enc[7:4] == APP_DATAREL);
  endfunction

endpackage
`default_nettype wire

>>> design/ehpsd_step.sv
// Combinational decode of one beat against the current decoder state.
`timescale 1ns / 1ps
`default_nettype none
module ehpsd_step
  import ehpsd_pkg::*;
(
  input  item_t      item_i,
  input  dec_state_t state_i,
  output dec_state_t state_o,
  output logic       emit_o,
  output result_t    result_o
);

  logic [3:0]  hold_len;
  logic [3:0]  start_len;
  logic [5:0]  uleb_shift;
  logic [5:0]  fix_shift;
  logic [63:0] acc_new;
  logic [7:0]  count_new;
  logic [8:0]  pos_next;
  logic        done;
  logic [63:0] final_value;

  assign hold_len   = fmt_len(state_i.encoding);
  assign start_len  = fmt_len(item_i.encoding);
  assign uleb_shift = 6'((state_i.count[3:0] * 4'd7) & 7'h3F);
  assign fix_shift  = {state_i.count[2:0], 3'b000};
  assign pos_next   = {1'b0, state_i.count} + 9'd1;

  // Merge the data byte into the accumulator
  always_comb begin
    acc_new = state_i.acc;
    if (hold_len == LEN_ULEB) begin
      if (state_i.count <= ULEB_LAST_GROUP) begin
        acc_new = state_i.acc | ({57'd0, item_i.data_byte[6:0] & GROUP_MASK} << uleb_shift);
      end
      done = !item_i.data_byte[7];
    end else begin
      if (state_i.count[7:3] == 5'd0) begin
        acc_new = state_i.acc | ({56'd0, item_i.data_byte} << fix_shift);
      end
      done = pos_next >= {5'd0, hold_len};
    end
    count_new = (state_i.count == COUNT_MAX) ? COUNT_MAX : pos_next[7:0];
  end

  // Width handling of the finished value
  always_comb begin
    final_value = acc_new;
    if (fmt_signed(state_i.encoding)) begin
      if (hold_len == 4'd2) begin
        final_value = {{48{acc_new[15]}}, acc_new[15:0]};
      end else if (hold_len == 4'd4) begin
        final_value = {{32{acc_new[31]}}, acc_new[31:0]};
      end
    end
  end

  // Next state and result
  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '{value: 64'd0, bytes_used: 8'd0, relocatable: 1'b0, status: ST_OK};
    if (item_i.cmd == CMD_START) begin
      state_o.busy  = 1'b0;
      state_o.acc   = 64'd0;
      state_o.count = 8'd0;
      if (item_i.encoding == ENC_OMIT) begin
        emit_o          = 1'b1;
        result_o.status = ST_OMIT;
      end else if (start_len == LEN_UNKNOWN) begin
        emit_o               = 1'b1;
        result_o.status      = ST_UNKNOWN;
        result_o.relocatable = is_reloc(item_i.encoding);
      end else begin
        state_o.busy     = 1'b1;
        state_o.encoding = item_i.encoding;
      end
    end else if (!state_i.busy) begin
      emit_o          = 1'b1;
      result_o.status = ST_NO_VALUE;
    end else if (!done) begin
      state_o.acc   = acc_new;
      state_o.count = count_new;
    end else begin
      emit_o               = 1'b1;
      result_o.value       = final_value;
      result_o.bytes_used  = count_new;
      result_o.relocatable = is_reloc(state_i.encoding);
      result_o.status      = ST_OK;
      state_o.busy         = 1'b0;
      state_o.acc          = 64'd0;
      state_o.count        = 8'd0;
    end
  end

endmodule
`default_nettype wire

>>> design/eh_pointer_stream_decoder_unit.sv
// Top level of the exception-table pointer stream decoder.
//
//   channel   | dir | tdata                               | tuser
//   s_axis    | in  | encoding[7:0], data_byte[15:8]      | command[0]
//   m_axis    | out | value[63:0], bytes_used[71:64],     | status[1:0]
//             |     | relocatable[72], zero[79:73]        |
//
// One beat per cycle sustained while m_axis does not stall; a beat goes through
// the input register, then decode into the result register.
// The decode of a beat is one shift-and-OR into the 64-bit accumulator plus
// sign extension, all combinational.
// Reset clears the decoder state and both valid flags; no warm-up after reset.
// A stall on m_axis fills the result register, then the input register, and
// only then drops s_axis_tready_o.
`timescale 1ns / 1ps
`default_nettype none
module eh_pointer_stream_decoder_unit
  import ehpsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // encoding[7:0], data_byte[15:8]
  input  wire logic [0:0]  s_axis_tuser_i,  // command[0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [79:0]      m_axis_tdata_o,  // value[63:0], bytes_used[71:64], relocatable[72]
  output logic [1:0]       m_axis_tuser_o   // status[1:0]
);

  logic       in_valid_q;
  item_t      in_item_q;
  logic       out_valid_q;
  result_t    out_res_q;
  dec_state_t state_q;
  dec_state_t state_d;
  logic       emit;
  result_t    res_d;
  logic       advance;
  logic       in_fire;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= '{cmd: cmd_e'(s_axis_tuser_i[0]), encoding: s_axis_tdata_i[7:0],
                     data_byte: s_axis_tdata_i[15:8]};
    end
  end

  ehpsd_step u_step (
    .item_i  (in_item_q),
    .state_i (state_q),
    .state_o (state_d),
    .emit_o  (emit),
    .result_o(res_d)
  );

  // Decoder state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance && in_valid_q) begin
      state_q     <= state_d;
      out_valid_q <= emit;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && emit) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_res_q.relocatable, out_res_q.bytes_used,
                            out_res_q.value};
  assign m_axis_tuser_o  = out_res_q.status;

  // Idle decoder holds a clean accumulator and count
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.busy |-> (state_q.acc == 64'd0) && (state_q.count == 8'd0))
    else $error("idle decoder with leftover accumulator or count");

  // Fixed-width fields never get past their last byte
  a_fixed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.busy && fmt_len(state_q.encoding) != LEN_ULEB) |-> state_q.count < 8'd8)
    else $error("fixed field byte count overrun");

  // A good result always consumed bytes; other statuses consumed none
  a_ok_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tuser_o == ST_OK) == (m_axis_tdata_o[71:64] != 8'd0)))
    else $error("bytes_used does not match status");

  // Non-ok results carry a zero value
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ST_OK) |-> m_axis_tdata_o[63:0] == 64'd0)
    else $error("status result with nonzero value");

  // A result beat leaves the decoder idle
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && emit) |=> !state_q.busy)
    else $error("decoder still busy after a result");

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the exception-table pointer stream decoder.
`timescale 1ns / 1ps
module tb_top;
  import ehpsd_pkg::*;

  // Clock, reset and port signals
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_data = '0;    // encoding[7:0], data_byte[15:8]
  logic [0:0]  s_user = '0;    // command[0]
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic [79:0] m_axis_tdata_o; // value[63:0], bytes_used[71:64], relocatable[72]
  logic [1:0]  m_axis_tuser_o; // status[1:0]

  // Decoder model state
  logic        dec_busy = 1'b0;
  logic [7:0]  dec_enc = '0;
  logic [63:0] dec_acc = '0;
  logic [7:0]  dec_count = '0;

  // Results still owed by the block, oldest first
  result_t     pending_values[$];

  // Run bookkeeping and traffic shaping
  int unsigned n_beats_in = 0;
  int unsigned n_beats_out = 0;
  int unsigned n_errors = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;

  eh_pointer_stream_decoder_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #10 clk_i = ~clk_i;

  // Field length in bytes: 0 for ULEB128, -1 for an unknown format
  function automatic int field_bytes(input logic [7:0] enc);
    case (enc[3:0])
      FMT_ULEB128:            return 0;
      FMT_UDATA2, FMT_SDATA2: return 2;
      FMT_UDATA4, FMT_SDATA4: return 4;
      FMT_UDATA8, FMT_SDATA8: return 8;
      default:                return -1;
    endcase
  endfunction

  function automatic logic app_reloc(input logic [7:0] enc);
    return enc[7:4] inside {APP_ABSPTR, APP_PCREL, APP_DATAREL};
  endfunction

  // Advance the decoder model by one beat; returns 1 when a result is due
  function automatic logic decode_beat(input cmd_e cmd, input logic [7:0] enc,
                                       input logic [7:0] db, output result_t res);
    int  len;
    int  sh;
    logic done;
    res = '0;
    if (cmd == CMD_START) begin
      dec_busy  = 1'b0;
      dec_acc   = '0;
      dec_count = '0;
      if (enc == ENC_OMIT) begin
        res.status = ST_OMIT;
        return 1'b1;
      end
      if (field_bytes(enc) < 0) begin
        res.relocatable = app_reloc(enc);
        res.status      = ST_UNKNOWN;
        return 1'b1;
      end
      dec_enc  = enc;
      dec_busy = 1'b1;
      return 1'b0;
    end
    // stray byte: flagged, state untouched
    if (!dec_busy) begin
      res.status = ST_NO_VALUE;
      return 1'b1;
    end
    len = field_bytes(dec_enc);
    if (len == 0) begin
      sh = int'(dec_count) * 7;
      if (sh < 64) dec_acc |= {57'd0, db[6:0]} << sh;
      done = !db[7];
    end else begin
      sh = int'(dec_count) * 8;
      if (sh < 64) dec_acc |= {56'd0, db} << sh;
      done = (int'(dec_count) + 1) >= len;
    end
    if (dec_count != COUNT_MAX) dec_count++;
    if (!done) return 1'b0;
    // sign-extend the short sdata forms
    if (dec_enc[3:0] == FMT_SDATA2) dec_acc = {{48{dec_acc[15]}}, dec_acc[15:0]};
    if (dec_enc[3:0] == FMT_SDATA4) dec_acc = {{32{dec_acc[31]}}, dec_acc[31:0]};
    res.value       = dec_acc;
    res.bytes_used  = dec_count;
    res.relocatable = app_reloc(dec_enc);
    res.status      = ST_OK;
    dec_busy  = 1'b0;
    dec_acc   = '0;
    dec_count = '0;
    return 1'b1;
  endfunction

  // Offer one beat, wait for it to be taken, then log what it should produce
  task automatic push_beat(input cmd_e cmd, input logic [7:0] enc, input logic [7:0] db);
    logic    taken;
    result_t res;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {db, enc};
    s_user  <= cmd;
    taken = 1'b0;
    while (!taken) begin
      // inputs only move at the rising edge, so the falling edge sees the edge values
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end
    n_beats_in++;
    if (decode_beat(cmd, enc, db, res)) pending_values.push_back(res);
  endtask

  task automatic push_start(input logic [7:0] enc);
    push_beat(CMD_START, enc, 8'($urandom));
  endtask

  task automatic push_byte(input logic [7:0] db);
    push_beat(CMD_BYTE, 8'($urandom), db);
  endtask

  // Well-formed value: start plus a complete byte field with random content
  task automatic push_value(input logic [7:0] enc);
    int len;
    int groups;
    len = field_bytes(enc);
    push_start(enc);
    if (len > 0) begin
      repeat (len) push_byte(8'($urandom));
    end else if (len == 0) begin
      groups = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
      for (int i = 0; i < groups; i++)
        push_byte({(i < groups - 1), 7'($urandom)});
    end
  endtask

  function automatic logic [7:0] known_encoding();
    logic [3:0] fmts[7] = '{FMT_ULEB128, FMT_UDATA2, FMT_UDATA4, FMT_UDATA8,
                            FMT_SDATA2, FMT_SDATA4, FMT_SDATA8};
    return {4'($urandom), fmts[$urandom_range(0, 6)]};
  endfunction

  // Receiver: random stall bursts, plus a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else if (burst_left != 0) begin
        m_ready <= 1'b0;
        burst_left--;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        m_ready <= 1'b0;
        burst_left = $urandom_range(1, 15) - 1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(negedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      n_beats_out++;
      if (pending_values.size() == 0) begin
        $error("unexpected result beat: value %h status %0d",
               m_axis_tdata_o[63:0], m_axis_tuser_o);
        n_errors++;
      end else begin
        want = pending_values.pop_front();
        if (m_axis_tdata_o[63:0] !== want.value) begin
          $error("value: expected %h, got %h", want.value, m_axis_tdata_o[63:0]);
          n_errors++;
        end
        if (m_axis_tdata_o[71:64] !== want.bytes_used) begin
          $error("bytes_used: expected %0d, got %0d", want.bytes_used, m_axis_tdata_o[71:64]);
          n_errors++;
        end
        if (m_axis_tdata_o[72] !== want.relocatable) begin
          $error("relocatable: expected %0d, got %0d", want.relocatable, m_axis_tdata_o[72]);
          n_errors++;
        end
        if (m_axis_tuser_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
          n_errors++;
        end
      end
    end
  end

  // Edge cases: unknown, omit, stray byte, sign extension, restart, long ULEB
  task automatic test_directed();
    push_start(8'h00);          // format 0 is unknown, absptr still relocatable
    push_start(ENC_OMIT);
    push_byte(8'hA5);           // nothing started
    push_start(8'h1A);          // pcrel sdata2, most negative
    push_byte(8'h00);
    push_byte(8'h80);
    push_start(8'h3B);          // datarel sdata4, most positive
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h7F);
    push_start(8'h42);          // udata2, cut short by the next start
    push_byte(8'hFF);
    push_start(8'h01);          // ULEB past bit 63
    repeat (10) push_byte(8'hFF);
    push_byte(8'h7F);
  endtask

  // ULEB run long enough to saturate the byte count
  task automatic test_uleb_saturation();
    push_start(8'hF1);
    repeat (300) push_byte({1'b1, 7'($urandom)});
    push_byte(8'h00);
    push_start(8'h2C);          // sdata8 all ones
    repeat (8) push_byte(8'hFF);
    push_start(8'h04);          // udata8 top bit set
    repeat (7) push_byte(8'h00);
    push_byte(8'h80);
  endtask

  // Long receiver hold-off while the sender keeps offering result-making beats
  task automatic test_output_stall();
    hold_left = 300;
    repeat (30) begin
      case ($urandom_range(0, 2))
        0:       push_start(ENC_OMIT);
        1:       push_byte(8'($urandom));
        default: push_start({4'($urandom), 4'h5});
      endcase
    end
  endtask

  // Mostly well-formed values, with noise and truncated sequences mixed in
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = n_beats_in + n_items;
    while (n_beats_in < stop_at) begin
      case ($urandom_range(0, 9))
        0:       push_start(8'($urandom));
        1:       push_byte(8'($urandom));
        2: begin
          push_start(known_encoding());
          repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
        end
        default: push_value(known_encoding());
      endcase
    end
  endtask

  // Main sequence
  initial begin : run
    int unsigned guard;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_uleb_saturation();
    test_output_stall();
    test_random_traffic(1425);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_traffic(200);
    s_valid <= 1'b0;

    // drain, then keep watching for anything unexpected
    guard = 0;
    while (pending_values.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_values.size() != 0) begin
      $error("results missing: %0d still expected", pending_values.size());
      n_errors++;
    end

    $display("Sent %0d beats and checked %0d results over all formats, omit, unknown,",
             n_beats_in, n_beats_out);
    $display("stray bytes, restarts, saturated ULEB runs and a long output stall.");
    if (n_errors == 0) begin
      $display("PASS eh_pointer_stream_decoder_unit");
    end else begin
      $display("FAIL eh_pointer_stream_decoder_unit");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("FAIL eh_pointer_stream_decoder_unit");
    $finish;
  end

endmodule

>>> filelist.f
design/ehpsd_pkg.sv
design/ehpsd_step.sv
design/eh_pointer_stream_decoder_unit.sv
tb/sv/tb_top.sv
